// ----- sv/lcgn_pkg.sv -----
// lcgn_pkg: constants, control word types and microcode table of the lcg noise unit
// no dependencies; imported by lcg_uniform_and_gaussian_noise_unit and by tb
`default_nettype none

package lcgn_pkg;

    // generator
    localparam logic [31:0] LCG_MUL  = 32'd1103515245;
    localparam logic [31:0] LCG_INC  = 32'd12345;
    localparam logic [31:0] SEED_RST = 32'd1;
    localparam int          DRAW_W   = 15;
    localparam int          DRAW_MAX = 32767;
    localparam int          AMP_W    = 16;
    localparam logic [AMP_W-1:0] AMP_RST = 16'd32767;
    localparam int          SAMPLE_W = 31;

    // gaussian sum length
    localparam int SUM_TERMS = 24;

    // datapath widths follow from the sum length
    localparam int MAG_W = $clog2(SUM_TERMS * DRAW_MAX + 1);  // |sum of terms|
    localparam int ACC_W = MAG_W + 2;                         // signed accumulator
    localparam int DW    = MAG_W + AMP_W;                     // product / dividend
    localparam int QW    = MAG_W + 1;                         // quotient bits
    localparam int REM_W = DW;                                // fold residue
    // folds for division by 2^15 - 1; three bring any dividend below 2^44 to 32767 or less
    localparam int DIV_STEPS = 3;
    localparam int CNT_MAX = (SUM_TERMS > DIV_STEPS) ? SUM_TERMS : DIV_STEPS;
    localparam int CNT_W   = $clog2(CNT_MAX);

    typedef enum logic [2:0] {
        OP_RESEED  = 3'd0,
        OP_DRAW15  = 3'd1,
        OP_DRAW30  = 3'd2,
        OP_UNIFORM = 3'd3,
        OP_SIGNED  = 3'd4,
        OP_GAUSS   = 3'd5
    } t_opcode;

    // control word fields
    typedef enum logic [1:0] {ADV_NONE, ADV_ALWAYS, ADV_IF_CNT} t_adv;
    typedef enum logic [2:0] {
        ACC_HOLD, ACC_CLEAR, ACC_LOAD_RAW, ACC_LOAD_TERM, ACC_ADD_TERM
    } t_acc;
    typedef enum logic [1:0] {CNT_HOLD, CNT_LOAD_TERMS, CNT_LOAD_DIV, CNT_DEC} t_cnt;
    typedef enum logic [1:0] {AR_NONE, AR_MUL, AR_DIV_INIT, AR_DIV_STEP} t_arith;
    typedef enum logic [1:0] {EMIT_NONE, EMIT_RAW15, EMIT_RAW30, EMIT_SCALED} t_emit;
    typedef enum logic [1:0] {JMP_NEXT, JMP_ALWAYS, JMP_IF_CNT, JMP_DISPATCH} t_jmp;

    localparam int UCODE_DEPTH = 17;
    localparam int PC_W        = $clog2(UCODE_DEPTH);

    typedef struct packed {
        t_adv            adv;
        t_acc            acc;
        t_cnt            cnt;
        t_arith          arith;
        t_emit           emit;
        logic            ld_seed;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    // microcode addresses
    localparam logic [PC_W-1:0] UA_FETCH = 5'd0;
    localparam logic [PC_W-1:0] UA_SEED  = 5'd1;
    localparam logic [PC_W-1:0] UA_D15_A = 5'd2;
    localparam logic [PC_W-1:0] UA_D15_B = 5'd3;
    localparam logic [PC_W-1:0] UA_D30_A = 5'd4;
    localparam logic [PC_W-1:0] UA_D30_B = 5'd5;
    localparam logic [PC_W-1:0] UA_D30_C = 5'd6;
    localparam logic [PC_W-1:0] UA_UNI_A = 5'd7;
    localparam logic [PC_W-1:0] UA_UNI_B = 5'd8;
    localparam logic [PC_W-1:0] UA_SGN_A = 5'd9;
    localparam logic [PC_W-1:0] UA_SGN_B = 5'd10;
    localparam logic [PC_W-1:0] UA_GAU_A = 5'd11;
    localparam logic [PC_W-1:0] UA_GAU_B = 5'd12;
    localparam logic [PC_W-1:0] UA_SCL_M = 5'd13;
    localparam logic [PC_W-1:0] UA_SCL_I = 5'd14;
    localparam logic [PC_W-1:0] UA_SCL_L = 5'd15;
    localparam logic [PC_W-1:0] UA_SCL_E = 5'd16;

    localparam t_uword UW_NOP = '{
        adv: ADV_NONE, acc: ACC_HOLD, cnt: CNT_HOLD, arith: AR_NONE,
        emit: EMIT_NONE, ld_seed: 1'b0, jmp: JMP_NEXT, target: UA_FETCH
    };

    // control store
    function automatic t_uword ucode(input logic [PC_W-1:0] addr);
        t_uword w;
        w = UW_NOP;
        unique case (addr)
            UA_FETCH: w.jmp = JMP_DISPATCH;
            UA_SEED: begin
                w.ld_seed = 1'b1;
                w.jmp     = JMP_ALWAYS;
            end
            UA_D15_A: w.adv = ADV_ALWAYS;
            UA_D15_B: begin
                w.emit = EMIT_RAW15;
                w.jmp  = JMP_ALWAYS;
            end
            UA_D30_A: w.adv = ADV_ALWAYS;
            UA_D30_B: begin
                w.acc = ACC_LOAD_RAW;
                w.adv = ADV_ALWAYS;
            end
            UA_D30_C: begin
                w.emit = EMIT_RAW30;
                w.jmp  = JMP_ALWAYS;
            end
            UA_UNI_A: w.adv = ADV_ALWAYS;
            UA_UNI_B: begin
                w.acc    = ACC_LOAD_RAW;
                w.jmp    = JMP_ALWAYS;
                w.target = UA_SCL_M;
            end
            UA_SGN_A: w.adv = ADV_ALWAYS;
            UA_SGN_B: begin
                w.acc    = ACC_LOAD_TERM;
                w.jmp    = JMP_ALWAYS;
                w.target = UA_SCL_M;
            end
            UA_GAU_A: begin
                w.adv = ADV_ALWAYS;
                w.acc = ACC_CLEAR;
                w.cnt = CNT_LOAD_TERMS;
            end
            UA_GAU_B: begin
                w.acc    = ACC_ADD_TERM;
                w.adv    = ADV_IF_CNT;
                w.cnt    = CNT_DEC;
                w.jmp    = JMP_IF_CNT;
                w.target = UA_GAU_B;
            end
            UA_SCL_M: w.arith = AR_MUL;
            UA_SCL_I: begin
                w.arith = AR_DIV_INIT;
                w.cnt   = CNT_LOAD_DIV;
            end
            UA_SCL_L: begin
                w.arith  = AR_DIV_STEP;
                w.cnt    = CNT_DEC;
                w.jmp    = JMP_IF_CNT;
                w.target = UA_SCL_L;
            end
            UA_SCL_E: begin
                w.emit = EMIT_SCALED;
                w.jmp  = JMP_ALWAYS;
            end
            default: w.jmp = JMP_ALWAYS;
        endcase
        return w;
    endfunction

    // microcode entry point for each opcode; unused opcodes go straight back to fetch
    function automatic logic [PC_W-1:0] entry_of(input logic [2:0] op);
        logic [PC_W-1:0] a;
        unique case (op)
            OP_RESEED:  a = UA_SEED;
            OP_DRAW15:  a = UA_D15_A;
            OP_DRAW30:  a = UA_D30_A;
            OP_UNIFORM: a = UA_UNI_A;
            OP_SIGNED:  a = UA_SGN_A;
            OP_GAUSS:   a = UA_GAU_A;
            default:    a = UA_FETCH;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- sv/lcg_uniform_and_gaussian_noise_unit.sv -----
// lcg_uniform_and_gaussian_noise_unit: microcoded lcg noise source, top level
// depends on lcgn_pkg (constants, control word types, microcode table)
`default_nettype none

// Noise source built on the 32-bit generator x = x*1103515245 + 12345, one
// draw being bits 30..16 of the new state. An item carries an opcode: reseed
// loads the state, draw15 and draw30 return raw draws, the uniform opcodes
// return d*s/32767 or (2d-32767)*s/32767, and gaussian sums SUM_TERMS signed
// terms and scales by s/65534, all truncated toward zero; s is the amplitude
// register, written through i_cfg_we while idle, a rule for the user that the
// block itself does not enforce. A small control store steps one control word
// per cycle unless an emit step stalls; the generator multiplier advances once
// a cycle and division by 32767 folds the high bits of the residue onto the low
// bits, DIV_STEPS (3) folds plus a final compare. A finished result sits in an
// output register, so the next item is taken while it waits; the emit step of
// that next item then holds while the previous result is still unclaimed.
module lcg_uniform_and_gaussian_noise_unit
    import lcgn_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // configuration
    input  wire                        i_cfg_we,
    input  wire  [AMP_W-1:0]           i_cfg_data,
    // input items
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire  [2:0]                 i_opcode,
    input  wire  [31:0]                i_seed_value,
    // result items
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    // sequencer
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_uword            w_uw;
    logic              w_accept;
    logic              w_stall;
    logic              w_cnt_nz;

    // datapath
    logic [31:0]             r_state, n_state;
    logic [AMP_W-1:0]        r_amp, n_amp;
    logic [2:0]              r_op, n_op;
    logic [31:0]             r_seed, n_seed;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [DW-1:0]           r_prod, n_prod;
    logic                    r_neg, n_neg;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [QW-1:0]           r_quo, n_quo;
    logic                    r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0]     r_sample, n_sample;

    logic [31:0]             w_lcg;
    logic [DRAW_W-1:0]       w_draw;
    logic signed [ACC_W-1:0] w_term;
    logic [ACC_W-1:0]        w_abs;
    logic [MAG_W-1:0]        w_mag;
    logic [DW-1:0]           w_prod;
    logic [DW-1:0]           w_dividend;
    logic [REM_W-DRAW_W-1:0] w_fold_hi;
    logic [REM_W-1:0]        w_fold;
    logic                    w_fold_full;
    logic [QW-1:0]           w_quo_fin;
    logic [SAMPLE_W-1:0]     w_q31;
    logic [SAMPLE_W-1:0]     w_scaled;

    // control word for the current step
    assign w_uw       = ucode(r_pc);
    assign o_in_ready = (r_pc == UA_FETCH);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cnt_nz   = (r_cnt != '0);
    // an emit step waits while the previous result is still unclaimed
    assign w_stall    = (w_uw.emit != EMIT_NONE) && r_out_valid && !i_out_ready;

    // generator and draw taken from the current state
    assign w_lcg  = r_state * LCG_MUL + LCG_INC;
    assign w_draw = r_state[30:16];

    // signed uniform term 2d - 32767
    assign w_term = $signed({{(ACC_W-DRAW_W-1){1'b0}}, w_draw, 1'b0})
                  - $signed(ACC_W'(DRAW_MAX));

    // magnitude times amplitude
    assign w_abs  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_mag  = w_abs[MAG_W-1:0];
    assign w_prod = {{AMP_W{1'b0}}, w_mag} * {{MAG_W{1'b0}}, r_amp};

    // division by 65534 is a halving followed by division by 32767
    assign w_dividend = (r_op == OP_GAUSS) ? (r_prod >> 1) : r_prod;

    // division by 32767 = 2^15 - 1: 2^15 leaves remainder 1, so adding the high
    // part to the quotient and folding it onto the low part keeps
    // dividend = quo * 32767 + residue
    assign w_fold_hi   = r_rem[REM_W-1:DRAW_W];
    assign w_fold      = REM_W'(w_fold_hi) + REM_W'(r_rem[DRAW_W-1:0]);
    // after the folds the residue is at most 32767; equal means one more
    assign w_fold_full = (r_rem >= REM_W'(DRAW_MAX));
    assign w_quo_fin   = r_quo + QW'(w_fold_full);

    // signed result from quotient and sign
    assign w_q31    = {{(SAMPLE_W-QW){1'b0}}, w_quo_fin};
    assign w_scaled = r_neg ? (SAMPLE_W'(0) - w_q31) : w_q31;

    // next program counter
    always_comb begin
        n_pc = r_pc;
        if (!w_stall) begin
            unique case (w_uw.jmp)
                JMP_NEXT:     n_pc = r_pc + PC_W'(1);
                JMP_ALWAYS:   n_pc = w_uw.target;
                JMP_IF_CNT:   n_pc = w_cnt_nz ? w_uw.target : r_pc + PC_W'(1);
                JMP_DISPATCH: n_pc = w_accept ? entry_of(i_opcode) : r_pc;
            endcase
        end
    end

    // loop counter shared by the term sum and the divider
    always_comb begin
        n_cnt = r_cnt;
        unique case (w_uw.cnt)
            CNT_HOLD:       n_cnt = r_cnt;
            CNT_LOAD_TERMS: n_cnt = CNT_W'(SUM_TERMS - 1);
            CNT_LOAD_DIV:   n_cnt = CNT_W'(DIV_STEPS - 1);
            CNT_DEC:        n_cnt = r_cnt - CNT_W'(1);
        endcase
    end

    // generator state and item latch
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_seed  = r_seed;
        n_amp   = i_cfg_we ? i_cfg_data : r_amp;
        if (w_accept) begin
            n_op   = i_opcode;
            n_seed = i_seed_value;
        end
        if (w_uw.ld_seed) begin
            n_state = r_seed;
        end else if (w_uw.adv == ADV_ALWAYS || (w_uw.adv == ADV_IF_CNT && w_cnt_nz)) begin
            n_state = w_lcg;
        end
    end

    // accumulator
    always_comb begin
        n_acc = r_acc;
        unique case (w_uw.acc)
            ACC_HOLD:      n_acc = r_acc;
            ACC_CLEAR:     n_acc = '0;
            ACC_LOAD_RAW:  n_acc = $signed({{(ACC_W-DRAW_W){1'b0}}, w_draw});
            ACC_LOAD_TERM: n_acc = w_term;
            ACC_ADD_TERM:  n_acc = r_acc + w_term;
            default:       n_acc = r_acc;
        endcase
    end

    // scaling: multiply, then divider setup and fold steps
    always_comb begin
        n_prod = r_prod;
        n_neg  = r_neg;
        n_rem  = r_rem;
        n_quo  = r_quo;
        unique case (w_uw.arith)
            AR_NONE: ;
            AR_MUL: begin
                n_prod = w_prod;
                n_neg  = r_acc[ACC_W-1];
            end
            AR_DIV_INIT: begin
                n_rem = w_dividend;
                n_quo = '0;
            end
            AR_DIV_STEP: begin
                n_rem = w_fold;
                n_quo = r_quo + QW'(w_fold_hi);
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_sample    = r_sample;
        if (!w_stall) begin
            unique case (w_uw.emit)
                EMIT_NONE: ;
                EMIT_RAW15: begin
                    n_out_valid = 1'b1;
                    n_sample    = {{(SAMPLE_W-DRAW_W){1'b0}}, w_draw};
                end
                EMIT_RAW30: begin
                    n_out_valid = 1'b1;
                    n_sample    = {1'b0, r_acc[DRAW_W-1:0], w_draw};
                end
                EMIT_SCALED: begin
                    n_out_valid = 1'b1;
                    n_sample    = w_scaled;
                end
            endcase
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= UA_FETCH;
            r_out_valid <= 1'b0;
            r_state     <= SEED_RST;
            r_amp       <= AMP_RST;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
            r_amp       <= n_amp;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_op     <= n_op;
        r_seed   <= n_seed;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_neg    <= n_neg;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_sample <= n_sample;
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = $signed(r_sample);

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking testbench for lcg_uniform_and_gaussian_noise_unit
// depends on lcgn_pkg (opcodes, widths, generator constants) and the unit itself
`timescale 1ns / 1ps

module tb
    import lcgn_pkg::*;
;

    // opcodes the unit ignores, kept by name
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 64;      // longest item is gaussian
    localparam int HOLD_CYCLES   = 400;     // long receiver back-pressure
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 225;     // four random phases, about 900 items
    localparam int MAX_REPORTS   = 10;

    // one directed stimulus row; known_val is used only where known is set
    typedef struct {
        bit                        cfg_we;
        logic [AMP_W-1:0]          cfg_val;
        logic [2:0]                op;
        logic [31:0]               seed;
        bit                        known;
        logic signed [SAMPLE_W-1:0] known_val;
    } t_stim_row;

    // one sample still owed by the unit
    typedef struct {
        t_opcode                    op;
        logic signed [SAMPLE_W-1:0] sample;
    } t_owed_sample;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [AMP_W-1:0]            i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [2:0]                  i_opcode;
    logic [31:0]                 i_seed_value;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [SAMPLE_W-1:0]  o_sample;

    lcg_uniform_and_gaussian_noise_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_seed_value (i_seed_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample     (o_sample)
    );

    // 12 ns clock, two phases of 6 ns
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // generator state and amplitude as the unit should hold them
    logic [31:0]      lcg_state;
    logic [AMP_W-1:0] amplitude;

    t_owed_sample     sample_q[$];

    // sideband that travels with the item in flight: a typed-in sample, if any
    bit                         item_known;
    logic signed [SAMPLE_W-1:0] item_known_val;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    int  mismatches;
    int  checked;
    int  cycle_count;
    int  op_seen[8];

    // one generator step, returns the 15-bit draw
    function automatic logic [DRAW_W-1:0] step_draw();
        lcg_state = lcg_state * LCG_MUL + LCG_INC;
        return lcg_state[30:16];
    endfunction

    // num * amplitude / den on magnitudes, truncated toward zero, kept to 31 bits
    function automatic logic [SAMPLE_W-1:0] scale_to_sample(input longint num,
                                                            input longint unsigned den);
        longint unsigned mag;
        longint unsigned quo;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        quo = mag * amplitude / den;
        if (num < 0)
            quo = -quo;
        return quo[SAMPLE_W-1:0];
    endfunction

    // predicted effect of one item; returns 1 when the item yields a sample
    function automatic bit predict_sample(input logic [2:0] op, input logic [31:0] seed,
                                          output logic [SAMPLE_W-1:0] smp);
        logic [DRAW_W-1:0] d1;
        logic [DRAW_W-1:0] d2;
        longint            acc;
        smp = '0;
        case (op)
            OP_RESEED: begin
                lcg_state = seed;
                return 1'b0;
            end
            OP_DRAW15: smp = {{(SAMPLE_W-DRAW_W){1'b0}}, step_draw()};
            OP_DRAW30: begin
                // the two draws are concatenated, the first draw in the high bits
                d1  = step_draw();
                d2  = step_draw();
                smp = {1'b0, d1, d2};
            end
            OP_UNIFORM: begin
                d1  = step_draw();
                smp = scale_to_sample(longint'(d1), DRAW_MAX);
            end
            OP_SIGNED: begin
                d1  = step_draw();
                smp = scale_to_sample(2 * longint'(d1) - DRAW_MAX, DRAW_MAX);
            end
            OP_GAUSS: begin
                acc = 0;
                for (int k = 0; k < SUM_TERMS; k++) begin
                    d1  = step_draw();
                    acc += 2 * longint'(d1) - DRAW_MAX;
                end
                smp = scale_to_sample(acc, 2 * DRAW_MAX);
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input logic signed [SAMPLE_W-1:0] want,
                                 input logic signed [SAMPLE_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch (%s): expected %0d, got %0d", what, want, got);
    endtask

    // scoreboard: checks outgoing samples, then predicts for accepted items
    always @(posedge i_clk) begin : scoreboard
        t_owed_sample         owed;
        logic [SAMPLE_W-1:0]  pred;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (sample_q.size() == 0) begin
                    note_mismatch("sample with nothing owed", '0, o_sample);
                end else begin
                    owed = sample_q.pop_front();
                    checked++;
                    if (o_sample !== owed.sample)
                        note_mismatch(owed.op.name(), owed.sample, o_sample);
                end
            end
            if (i_cfg_we)
                amplitude = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                op_seen[i_opcode]++;
                if (predict_sample(i_opcode, i_seed_value, pred)) begin
                    owed.op     = t_opcode'(i_opcode);
                    owed.sample = item_known ? item_known_val : pred;
                    sample_q.push_back(owed);
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // cycle counter; a stuck run ends here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d samples still owed", cycle_count,
                 sample_q.size());
        $display("tb failed");
        $finish;
    end

    // offer one item, called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [2:0] op, input logic [31:0] seed,
                             input bit known, input logic signed [SAMPLE_W-1:0] known_val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_opcode       = op;
        i_seed_value   = seed;
        item_known     = known;
        item_known_val = known_val;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // wait until every owed sample is out and the last silent item has finished
    task automatic drain_and_settle();
        i_in_valid = 1'b0;
        while (sample_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_amplitude(input logic [AMP_W-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // random item mix: mostly draws with live content, some reseeds and unused codes
    task automatic send_random_item(output bit counts);
        int          r;
        logic [2:0]  op;
        r      = $urandom_range(0, 99);
        counts = 1'b1;
        if (r < 8)       op = OP_RESEED;
        else if (r < 12) begin
            op     = $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
            counts = 1'b0;
        end
        else if (r < 30) op = OP_DRAW15;
        else if (r < 45) op = OP_DRAW30;
        else if (r < 62) op = OP_UNIFORM;
        else if (r < 80) op = OP_SIGNED;
        else             op = OP_GAUSS;
        send_item(op, $urandom(), 1'b0, '0);
    endtask

    t_stim_row        dir_rows[];
    logic [31:0]      mul_inv;
    logic [31:0]      seed_top;
    logic [AMP_W-1:0] phase_amp[4];
    bit               counts;
    int               sent;

    initial begin
        // every input known from time zero, reset held low
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_RESEED;
        i_seed_value   = '0;
        item_known     = 1'b0;
        item_known_val = '0;
        hold_req       = 1'b0;
        mismatches     = 0;
        checked        = 0;
        lcg_state      = SEED_RST;
        amplitude      = AMP_RST;
        foreach (op_seen[i]) op_seen[i] = 0;
        send_idle_pct  = 12;
        recv_idle_pct  = 66;

        // seed whose next state is 0x7fff0000, so the next draw is the largest one;
        // inverse of the multiplier mod 2^32 by newton iteration
        mul_inv = LCG_MUL;
        repeat (5) mul_inv = mul_inv * (32'd2 - LCG_MUL * mul_inv);
        seed_top = (32'h7FFF_0000 - LCG_INC) * mul_inv;

        // directed part: reset state, unused codes, draw extremes, amplitude extremes
        dir_rows = '{
            '{0, 0,     OP_DRAW15,   0,            1, 16838},   // first draw after reset
            '{0, 0,     OP_UNUSED_6, 32'hFFFF_FFFF, 0, 0},
            '{0, 0,     OP_UNUSED_7, 32'hFFFF_FFFF, 0, 0},
            '{0, 0,     OP_DRAW15,   0,            0, 0},       // state untouched by both
            '{0, 0,     OP_RESEED,   0,            0, 0},
            '{0, 0,     OP_DRAW15,   0,            1, 0},       // smallest draw
            '{0, 0,     OP_RESEED,   seed_top,     0, 0},
            '{0, 0,     OP_DRAW15,   0,            1, 32767},   // largest draw
            '{0, 0,     OP_RESEED,   seed_top,     0, 0},
            '{0, 0,     OP_UNIFORM,  0,            1, 32767},
            '{0, 0,     OP_RESEED,   seed_top,     0, 0},
            '{0, 0,     OP_SIGNED,   0,            1, 32767},
            '{0, 0,     OP_RESEED,   0,            0, 0},
            '{0, 0,     OP_SIGNED,   0,            1, -32767},
            '{0, 0,     OP_DRAW30,   0,            0, 0},
            '{0, 0,     OP_GAUSS,    0,            0, 0},
            '{0, 0,     OP_RESEED,   32'hFFFF_FFFF, 0, 0},
            '{0, 0,     OP_DRAW30,   0,            0, 0},
            '{1, 0,     OP_UNIFORM,  0,            1, 0},       // zero amplitude
            '{0, 0,     OP_SIGNED,   0,            1, 0},
            '{0, 0,     OP_GAUSS,    0,            1, 0},
            '{0, 0,     OP_DRAW15,   0,            0, 0},       // generator still moved on
            '{1, 65535, OP_RESEED,   seed_top,     0, 0},       // full amplitude
            '{0, 0,     OP_UNIFORM,  0,            1, 65535},
            '{0, 0,     OP_RESEED,   0,            0, 0},
            '{0, 0,     OP_SIGNED,   0,            1, -65535},
            '{0, 0,     OP_GAUSS,    0,            0, 0}
        };

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_we) begin
                drain_and_settle();
                write_amplitude(dir_rows[i].cfg_val);
            end
            send_item(dir_rows[i].op, dir_rows[i].seed, dir_rows[i].known,
                      dir_rows[i].known_val);
        end

        // random part: four amplitude settings, idling pattern set per phase
        phase_amp[0] = AMP_W'($urandom_range(2, 65534));
        phase_amp[1] = 16'd1;
        phase_amp[2] = 16'd65535;
        phase_amp[3] = AMP_W'($urandom_range(2, 65534));
        for (int ph = 0; ph < 4; ph++) begin
            drain_and_settle();
            write_amplitude(phase_amp[ph]);
            case (ph)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 66;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // receiver stops for a long stretch while items keep coming
            if (ph == 2)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                send_random_item(counts);
                if (counts)
                    sent++;
            end
        end

        drain_and_settle();

        $display("run covered %0d reseeds, %0d draw15, %0d draw30, %0d uniform, %0d signed,",
                 op_seen[OP_RESEED], op_seen[OP_DRAW15], op_seen[OP_DRAW30],
                 op_seen[OP_UNIFORM], op_seen[OP_SIGNED]);
        $display("  %0d gaussian, %0d ignored codes; %0d samples checked, %0d bad, %0d cycles",
                 op_seen[OP_GAUSS], op_seen[OP_UNUSED_6] + op_seen[OP_UNUSED_7], checked,
                 mismatches, cycle_count);
        if (mismatches == 0 && sample_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
